>>> hdl/eca_pkg.sv
// Shared types, codes and helpers for the encoder click and acceleration block.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package eca_pkg;

	localparam int unsigned TimeWidth  = 32;
	localparam int unsigned CountWidth = 8;
	localparam int unsigned MultWidth  = 7;
	localparam int unsigned DeltaWidth = 8;

	localparam logic [CountWidth-1:0] FAST_THRESHOLD = 8'd3;
	localparam logic [CountWidth-1:0] COUNT_MAX      = 8'd255;

	localparam logic [TimeWidth-1:0] DCW_RESET  = 32'd500000;
	localparam logic [TimeWidth-1:0] FSW_RESET  = 32'd200000;
	localparam logic [TimeWidth-1:0] FEW_RESET  = 32'd1000000;
	localparam logic [MultWidth-1:0] MULT_RESET = 7'd5;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_UP      = 2'd1,
		OP_DOWN    = 2'd2,
		OP_UNKNOWN = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SELECT = 2'd1,
		KIND_DOUBLE = 2'd2,
		KIND_DELTA  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_DOUBLE_CLICK_WINDOW = 2'd0,
		REG_FAST_STEP_WINDOW    = 2'd1,
		REG_FAST_EXPIRE_WINDOW  = 2'd2,
		REG_FAST_MULTIPLIER     = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [TimeWidth-1:0] double_click_window;
		logic [TimeWidth-1:0] fast_step_window;
		logic [TimeWidth-1:0] fast_expire_window;
		logic [MultWidth-1:0] fast_multiplier;
	} cfg_t;

	typedef struct packed {
		kind_t                        kind;
		logic signed [DeltaWidth-1:0] delta;
	} result_t;

	// Counter increment that sticks at the top value.
	function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
		return (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
	endfunction

endpackage

>>> hdl/eca_cfg_regs.sv
// Configuration register file: the three time windows and the fast multiplier.
// Depends on eca_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps

module eca_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output eca_pkg::cfg_t        cfg
);
	import eca_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.double_click_window <= DCW_RESET;
			cfg_q.fast_step_window    <= FSW_RESET;
			cfg_q.fast_expire_window  <= FEW_RESET;
			cfg_q.fast_multiplier     <= MULT_RESET;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_DOUBLE_CLICK_WINDOW: cfg_q.double_click_window <= cfg_data;
				REG_FAST_STEP_WINDOW:    cfg_q.fast_step_window    <= cfg_data;
				REG_FAST_EXPIRE_WINDOW:  cfg_q.fast_expire_window  <= cfg_data;
				REG_FAST_MULTIPLIER:     cfg_q.fast_multiplier     <= cfg_data[MultWidth-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/eca_event_core.sv
// Event interpreter: press and step history registers plus the logic that turns
// one event into a result. Depends on eca_pkg for codes, types and sat_inc.
`timescale 1ns / 1ps

module eca_event_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           opcode,
	input  logic [31:0]          event_time,
	input  eca_pkg::cfg_t        cfg,
	output eca_pkg::result_t     result
);
	import eca_pkg::*;

	logic [1:0]            last_opcode_q;
	logic [TimeWidth-1:0]  press_time_q, up_time_q, down_time_q;
	logic [CountWidth-1:0] press_count_q, up_count_q, down_count_q;

	logic [TimeWidth-1:0]  press_gap, own_time, step_gap;
	logic [CountWidth-1:0] own_count, own_count_d;
	logic [CountWidth-1:0] press_count_d, up_count_d, down_count_d;
	logic                  same_dir, is_double;
	logic [MultWidth-1:0]  magnitude;
	logic [DeltaWidth-1:0] step_mag;

	always_comb begin
		press_gap = event_time - press_time_q;
		is_double = (press_gap < cfg.double_click_window) &&
			(last_opcode_q == OP_PRESS) && (press_count_q != '0);

		own_time  = (opcode == OP_UP) ? up_time_q : down_time_q;
		own_count = (opcode == OP_UP) ? up_count_q : down_count_q;
		step_gap  = event_time - own_time;
		same_dir  = (last_opcode_q == opcode);

		// In the same direction, a gap between the fast and expire windows keeps the count as it is.
		own_count_d = own_count;
		if (step_gap < cfg.fast_step_window && same_dir) begin
			own_count_d = sat_inc(own_count);
		end else if (step_gap > cfg.fast_expire_window || !same_dir) begin
			own_count_d = 8'd1;
		end

		magnitude = (own_count_d > FAST_THRESHOLD) ? cfg.fast_multiplier : 7'd1;
		step_mag  = {1'b0, magnitude};

		press_count_d = press_count_q;
		up_count_d    = up_count_q;
		down_count_d  = down_count_q;
		result.kind   = KIND_NONE;
		result.delta  = '0;

		unique case (opcode_t'(opcode))
			OP_PRESS: begin
				up_count_d   = '0;
				down_count_d = '0;
				if (is_double) begin
					result.kind   = KIND_DOUBLE;
					press_count_d = '0;
				end else begin
					result.kind   = KIND_SELECT;
					press_count_d = sat_inc(press_count_q);
				end
			end
			OP_UP: begin
				press_count_d = '0;
				down_count_d  = '0;
				up_count_d    = own_count_d;
				result.kind   = KIND_DELTA;
				result.delta  = $signed(step_mag);
			end
			OP_DOWN: begin
				press_count_d = '0;
				up_count_d    = '0;
				down_count_d  = own_count_d;
				result.kind   = KIND_DELTA;
				result.delta  = $signed(~step_mag + 8'd1);
			end
			OP_UNKNOWN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_opcode_q <= OP_PRESS;
			press_time_q  <= '0;
			press_count_q <= '0;
			up_time_q     <= '0;
			up_count_q    <= '0;
			down_time_q   <= '0;
			down_count_q  <= '0;
		end else if (accept) begin
			last_opcode_q <= opcode;
			press_count_q <= press_count_d;
			up_count_q    <= up_count_d;
			down_count_q  <= down_count_d;
			if (opcode == OP_PRESS && !is_double) begin
				press_time_q <= event_time;
			end
			if (opcode == OP_UP) begin
				up_time_q <= event_time;
			end
			if (opcode == OP_DOWN) begin
				down_time_q <= event_time;
			end
		end
	end

	// A press leaves both step counts at zero.
	a_press_clears_steps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_PRESS |=> up_count_q == '0 && down_count_q == '0)
		else $error("press did not clear step counts");

	// A step breaks any double click sequence.
	a_step_clears_press: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (opcode == OP_UP || opcode == OP_DOWN) |=> press_count_q == '0)
		else $error("step did not clear press count");

	// An unknown code touches no counter and no timestamp.
	a_unknown_keeps_history: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_UNKNOWN |=> $stable(press_count_q) && $stable(up_count_q)
			&& $stable(down_count_q) && $stable(press_time_q) && $stable(up_time_q)
			&& $stable(down_time_q))
		else $error("unknown code changed history");

endmodule

>>> hdl/eca_out_reg.sv
// Result register between the event logic and the output channel; it takes a
// new result in the cycle the old one is transferred. Depends on eca_pkg.
`timescale 1ns / 1ps

module eca_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  eca_pkg::result_t     result,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           event_kind,
	output logic signed [7:0]    step_delta
);
	import eca_pkg::*;

	logic    out_valid_q;
	result_t result_q;

	assign in_ready   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign event_kind = result_q.kind;
	assign step_delta = result_q.delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			result_q <= result;
		end
	end

	// Only a value delta carries a nonzero step.
	a_delta_only_with_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.kind != KIND_DELTA |-> result_q.delta == '0)
		else $error("nonzero step delta on a non-delta result");

endmodule

>>> hdl/encoder_click_and_acceleration.sv
// Rotary encoder event interpreter with double click detection and step
// acceleration.
//
// Input channel (in_valid/in_ready, opcode, event_time): one timestamped
// encoder event per transfer. Output channel (out_valid/out_ready, event_kind,
// step_delta): exactly one result per input event, in order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes the
// double click window, the fast step and expire windows and the fast
// multiplier; cfg_ready is always high. Write only while the block is idle.
//
// The result is registered: the result of an event appears on the output in the
// cycle after its transfer. Throughput is one event per cycle while the
// receiver takes results, set by the history registers that each event rewrites.
// When the receiver stalls, the result register holds its result and in_ready
// stays high only if that result is transferred in the same cycle.
// Reset clears all press and step history and loads the default windows
// (500000, 200000, 1000000 us) and a multiplier of five; no clearing pass.
// Depends on eca_pkg, eca_cfg_regs, eca_event_core and eca_out_reg.
`timescale 1ns / 1ps

module encoder_click_and_acceleration (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [31:0]          event_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           event_kind,
	output logic signed [7:0]    step_delta,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import eca_pkg::*;

	cfg_t    cfg;
	result_t result;
	logic    accept;

	assign accept = in_valid && in_ready;

	eca_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eca_event_core u_event_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.event_time (event_time),
		.cfg        (cfg),
		.result     (result)
	);

	eca_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.result     (result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.step_delta (step_delta)
	);

endmodule

>>> dv/eca_event_checker.sv
// Checker for the encoder click and acceleration block: watches all three channels,
// predicts each result from its own copy of the event history and compares in order.
// Depends on eca_pkg for the opcode, kind, register index and result types.
`timescale 1ns / 1ps

module eca_event_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [31:0]       event_time,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        event_kind,
	input  logic signed [7:0] step_delta,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output int                mismatches,
	output int                outstanding,
	output int                doubles,
	output int                boosted
);
	import eca_pkg::*;

	localparam logic [7:0] ACCEL_AFTER = 8'd3;

	result_t     pending_results[$];
	cfg_t        windows;
	opcode_t     prev_op;
	logic [31:0] press_at;
	logic [31:0] up_at;
	logic [31:0] down_at;
	logic [7:0]  press_n;
	logic [7:0]  up_n;
	logic [7:0]  down_n;
	int          fail_total;
	int          double_total;
	int          boost_total;

	function automatic logic [7:0] count_up(input logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	// Applies one event to the history and returns the result it should produce.
	function automatic result_t interpret_event(input opcode_t op, input logic [31:0] now);
		result_t     r;
		logic [31:0] gap;
		logic [7:0]  n;
		logic [7:0]  mag;
		r.kind  = KIND_NONE;
		r.delta = '0;
		case (op)
			OP_PRESS: begin
				up_n   = '0;
				down_n = '0;
				gap    = now - press_at;
				if (gap < windows.double_click_window && prev_op == OP_PRESS && press_n != 0) begin
					r.kind  = KIND_DOUBLE;
					press_n = '0;
					double_total++;
				end else begin
					r.kind   = KIND_SELECT;
					press_n  = count_up(press_n);
					press_at = now;
				end
			end
			OP_UP, OP_DOWN: begin
				gap     = now - ((op == OP_UP) ? up_at : down_at);
				n       = (op == OP_UP) ? up_n : down_n;
				press_n = '0;
				if (gap < windows.fast_step_window && prev_op == op)
					n = count_up(n);
				else if (gap > windows.fast_expire_window || prev_op != op)
					n = 8'd1;
				// In the same direction, a gap between the two windows leaves the count where it was.
				if (op == OP_UP) begin
					up_n   = n;
					up_at  = now;
					down_n = '0;
				end else begin
					down_n  = n;
					down_at = now;
					up_n    = '0;
				end
				if (n > ACCEL_AFTER) begin
					mag = {1'b0, windows.fast_multiplier};
					boost_total++;
				end else begin
					mag = 8'd1;
				end
				r.kind  = KIND_DELTA;
				r.delta = (op == OP_UP) ? mag : 8'd0 - mag;
			end
			default: ;
		endcase
		prev_op = op;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			windows.double_click_window = DCW_RESET;
			windows.fast_step_window    = FSW_RESET;
			windows.fast_expire_window  = FEW_RESET;
			windows.fast_multiplier     = MULT_RESET;
			prev_op  = OP_PRESS;
			press_at = '0;
			up_at    = '0;
			down_at  = '0;
			press_n  = '0;
			up_n     = '0;
			down_n   = '0;
			pending_results.delete();
			fail_total   = 0;
			double_total = 0;
			boost_total  = 0;
			mismatches  <= 0;
			outstanding <= 0;
			doubles     <= 0;
			boosted     <= 0;
		end else begin : watch
			result_t seen;
			result_t want;
			// A result leaves in the cycle after its event at the earliest, so the
			// output side is always checked against events of earlier edges.
			if (out_valid && out_ready) begin
				seen.kind  = kind_t'(event_kind);
				seen.delta = step_delta;
				if (pending_results.size() == 0) begin
					fail_total++;
					$error("result transfer with no event waiting: event_kind %0d, step_delta %0d",
						event_kind, step_delta);
				end else begin
					want = pending_results.pop_front();
					if (seen.kind !== want.kind) begin
						fail_total++;
						$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
					end
					if (seen.delta !== want.delta) begin
						fail_total++;
						$error("step_delta: expected %0d, got %0d", want.delta, step_delta);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_DOUBLE_CLICK_WINDOW: windows.double_click_window = cfg_data;
					REG_FAST_STEP_WINDOW:    windows.fast_step_window    = cfg_data;
					REG_FAST_EXPIRE_WINDOW:  windows.fast_expire_window  = cfg_data;
					REG_FAST_MULTIPLIER:     windows.fast_multiplier     = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_results.push_back(interpret_event(opcode_t'(opcode), event_time));
			mismatches  <= fail_total;
			outstanding <= pending_results.size();
			doubles     <= double_total;
			boosted     <= boost_total;
		end
	end

endmodule

>>> dv/encoder_click_and_acceleration_test.sv
// Testbench top for encoder_click_and_acceleration: drives events and register writes
// with random pacing on both sides, and reports the verdict from eca_event_checker.
// Depends on eca_pkg, the block under hdl and dv/eca_event_checker.sv.
`timescale 1ns / 1ps

module encoder_click_and_acceleration_test;
	import eca_pkg::*;

	localparam int QUIET_LIMIT = 200;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [1:0]        opcode     = '0;
	logic [31:0]       event_time = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [1:0]        event_kind;
	logic signed [7:0] step_delta;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index  = '0;
	logic [31:0]       cfg_data   = '0;

	int mismatches;
	int outstanding;
	int doubles;
	int boosted;

	// Current register values, used to aim the event spacing at the window edges.
	logic [31:0] dcw  = DCW_RESET;
	logic [31:0] fsw  = FSW_RESET;
	logic [31:0] few  = FEW_RESET;

	logic [31:0] stamp_now   = '0;
	int          events_sent = 0;
	int          settings    = 1;
	logic        steady      = 1'b0;
	int          rx_wait     = 0;
	int          quiet       = 0;

	encoder_click_and_acceleration u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.event_time (event_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.step_delta (step_delta),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	eca_event_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.event_time  (event_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.step_delta  (step_delta),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.doubles     (doubles),
		.boosted     (boosted)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: pauses ready at random after each result transfer, except when steady.
	always @(posedge clk or negedge arst_n) begin : rx_pace
		int hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
		end else if (out_valid && out_ready) begin
			hold = steady ? 0 : $urandom_range(0, 4);
			out_ready <= (hold == 0);
			rx_wait   <= hold;
		end else if (rx_wait != 0) begin
			out_ready <= (rx_wait == 1);
			rx_wait   <= rx_wait - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_event(input opcode_t op, input logic [31:0] stamp);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		event_time <= stamp;
		do @(posedge clk); while (!in_ready);
		events_sent++;
	endtask

	task automatic step_by(input opcode_t op, input logic [31:0] gap);
		stamp_now = stamp_now + gap;
		send_event(op, stamp_now);
	endtask

	// Stop sending and wait until every predicted result has been transferred.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [31:0] dc, input logic [31:0] fs,
			input logic [31:0] fe, input logic [6:0] mul);
		logic [31:0] word;
		// Upper bits of the multiplier write are junk and must be dropped.
		word      = $urandom;
		word[6:0] = mul;
		put_reg(REG_DOUBLE_CLICK_WINDOW, dc);
		put_reg(REG_FAST_STEP_WINDOW, fs);
		put_reg(REG_FAST_EXPIRE_WINDOW, fe);
		put_reg(REG_FAST_MULTIPLIER, word);
		cfg_valid <= 1'b0;
		dcw  = dc;
		fsw  = fs;
		few  = fe;
		settings++;
	endtask

	// Spacing that clusters around window w, with full-range, in-between and beyond-expire gaps mixed in.
	function automatic logic [31:0] pick_gap(input logic [31:0] w);
		case ($urandom_range(0, 9))
			0: return w;
			1: return w - 32'd1;
			2: return w + 32'd1;
			3: return $urandom;
			4: return few + $urandom_range(1, 1000);
			5: return $urandom_range(fsw, few);
			default: return (w == 0) ? 32'd0 : $urandom_range(0, w - 32'd1);
		endcase
	endfunction

	task automatic random_segment();
		int      len;
		int      pick;
		opcode_t dir;
		len  = $urandom_range(1, 12);
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			dir = $urandom_range(0, 1) ? OP_UP : OP_DOWN;
			repeat (len) step_by(dir, pick_gap(fsw));
		end else if (pick < 8) begin
			repeat (len) step_by(OP_PRESS, pick_gap(dcw));
		end else begin
			repeat (len) begin
				if ($urandom_range(0, 3) == 0) begin
					stamp_now = $urandom;
					send_event(opcode_t'($urandom_range(0, 3)), stamp_now);
				end else begin
					step_by(opcode_t'($urandom_range(0, 3)), pick_gap(few));
				end
			end
		end
	endtask

	task automatic run_random(input int count);
		int target;
		target = events_sent + count;
		while (events_sent < target) begin
			if ($urandom_range(0, 39) == 0)
				drain();
			random_segment();
		end
	endtask

	task automatic run_directed();
		step_by(OP_PRESS, 0);
		step_by(OP_PRESS, 10);
		step_by(OP_PRESS, 10);
		step_by(OP_PRESS, 500000);
		step_by(OP_PRESS, 499999);
		step_by(OP_UNKNOWN, 1);
		step_by(OP_PRESS, 10);
		step_by(OP_UNKNOWN, 1);
		step_by(OP_PRESS, 10);
		step_by(OP_UP, 10);
		repeat (4) step_by(OP_UP, 1);
		step_by(OP_UP, 200000);
		step_by(OP_UP, 199999);
		step_by(OP_UP, 1000001);
		stamp_now = 32'hFFFF_FFFF;
		send_event(OP_DOWN, stamp_now);
		step_by(OP_DOWN, 6);
		step_by(OP_DOWN, 1);
		step_by(OP_DOWN, 1);
		step_by(OP_UNKNOWN, 1);
		step_by(OP_DOWN, 1);
		step_by(OP_PRESS, 1);
		step_by(OP_UP, 1000000);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(120);

		// With a zero window every press is a select, so the press count saturates.
		drain();
		configure('0, '0, '0, 7'd0);
		run_random(120);
		repeat (260) step_by(OP_PRESS, $urandom_range(0, 9));

		// The saturated press count must still give a double click here.
		drain();
		steady = 1'b1;
		configure('1, '1, '1, 7'd127);
		step_by(OP_PRESS, 5);
		run_random(120);
		repeat (300) step_by(OP_UP, $urandom_range(0, 3));

		drain();
		steady = 1'b0;
		configure(32'd100, 32'd50, 32'd300, 7'd1);
		run_random(120);

		drain();
		configure($urandom, $urandom_range(0, 400000), $urandom_range(0, 2000000),
			7'($urandom_range(1, 127)));
		run_random(120);

		// Fast window wider than the expire window.
		drain();
		configure(32'd40000, 32'd5000, 32'd2000, 7'($urandom_range(1, 127)));
		run_random(120);

		drain();
		repeat (4) @(posedge clk);
		$display("covered %0d encoder events under %0d register settings, zero and full-scale",
			events_sent, settings);
		$display("windows and multipliers 0 and 127 included; %0d double clicks, %0d fast steps",
			doubles, boosted);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
hdl/eca_pkg.sv
hdl/eca_cfg_regs.sv
hdl/eca_event_core.sv
hdl/eca_out_reg.sv
hdl/encoder_click_and_acceleration.sv
dv/eca_event_checker.sv
dv/encoder_click_and_acceleration_test.sv
